FILE: rtl/core/orwa_pkg.sv
package orwa_pkg;

  localparam int TOL_W      = 7;
  localparam int AVG_W      = 10;
  localparam int COUNT_W    = 4;
  localparam int FACTOR_W   = 8;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  localparam logic [TOL_W-1:0]    TOL_RESET     = 7'd10;
  localparam logic [FACTOR_W-1:0] PERCENT_SCALE = 8'd100;

  // register index, taken from paddr[2]
  localparam logic REG_TOLERANCE = 1'b0;

endpackage

FILE: rtl/core/orwa_if.sv
interface orwa_sample_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface orwa_result_if;
  import orwa_pkg::*;
  logic               valid;
  logic               ready;
  logic [AVG_W-1:0]   filtered_average;
  logic [COUNT_W-1:0] kept_count;

  modport source (output valid, output filtered_average, output kept_count, input ready);
  modport sink   (input valid, input filtered_average, input kept_count, output ready);
endinterface

FILE: rtl/core/outlier_rejecting_window_average_core.sv
// channel   dir  payload                                   transfer when
// samples   in   sample[SAMPLE_BITS-1:0]                   valid && ready
// results   out  filtered_average[9:0], kept_count[3:0]    valid && ready
// config    in   apb, tolerance_percent at 0x0             psel && penable && pwrite
//
// one sample takes up to two rotations of the window plus two runs of the serial divider,
// whose dividend is SUM_W = SAMPLE_BITS + clog2(WINDOW_DEPTH) bits wide;
// samples.ready is high only between items
// a finished result waits in the output register, the next sample is taken meanwhile;
// a second result waits in the sequencer until the first one is transferred
// synchronous reset clears the window to zeros and tolerance to 10
module outlier_rejecting_window_average_core #(
  parameter int WINDOW_DEPTH = 10,
  parameter int SAMPLE_BITS  = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [orwa_pkg::ADDR_W-1:0]   paddr,
  input  logic [orwa_pkg::DATA_W-1:0]   pwdata,
  output logic [orwa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  orwa_sample_if.sink                   samples,
  orwa_result_if.source                 results
);
  import orwa_pkg::*;

  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int PROD_W = SAMPLE_BITS + FACTOR_W;

  typedef enum logic [2:0] {
    IDLE, PASS1, LOAD1, DIV1, SCALE, PASS2, LOAD2, DIV2
  } state_t;

  state_t                 state;
  logic                   finish;
  logic [TOL_W-1:0]       tolerance;
  logic [SAMPLE_BITS-1:0] window [WINDOW_DEPTH];
  logic [IDX_W-1:0]       idx;
  logic [SUM_W-1:0]       sum;
  logic [CNT_W-1:0]       cnt1;
  logic [CNT_W-1:0]       cnt2;
  logic [SAMPLE_BITS-1:0] mean;
  logic [PROD_W-1:0]      lo;
  logic [PROD_W-1:0]      hi;
  logic [SAMPLE_BITS-1:0] res;
  logic [CNT_W-1:0]       kept;

  logic                   accept;
  logic                   last;
  logic [SAMPLE_BITS-1:0] tail;
  logic [PROD_W-1:0]      scaled;
  logic                   take1;
  logic                   take2;
  logic [SUM_W-1:0]       sum_next;
  logic [CNT_W-1:0]       cnt1_next;
  logic [CNT_W-1:0]       cnt2_next;
  logic                   div_start;
  logic [CNT_W-1:0]       div_divisor;
  logic                   div_done;
  logic [SUM_W-1:0]       div_quotient;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOLERANCE) ? DATA_W'(tolerance) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TOLERANCE) begin
      tolerance <= pwdata[TOL_W-1:0];
    end
  end

  assign samples.ready = (state == IDLE) && !finish;
  assign accept        = samples.valid && samples.ready;
  assign last          = idx == IDX_W'(WINDOW_DEPTH - 1);
  assign tail          = window[WINDOW_DEPTH-1];
  assign scaled        = PROD_W'(tail) * PROD_W'(PERCENT_SCALE);
  assign take1         = tail != '0;
  assign take2         = scaled >= lo && scaled <= hi;
  assign sum_next      = sum + SUM_W'(tail);
  assign cnt1_next     = cnt1 + CNT_W'(1);
  assign cnt2_next     = cnt2 + CNT_W'(1);
  assign div_start     = (state == LOAD1) || (state == LOAD2);
  assign div_divisor   = (state == LOAD1) ? cnt1 : cnt2;

  orwa_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // window shifts on insert and rotates during each pass
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) window[i] <= '0;
    end else if (accept || state == PASS1 || state == PASS2) begin
      window[0] <= accept ? samples.sample : tail;
      for (int i = 1; i < WINDOW_DEPTH; i++) window[i] <= window[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      finish        <= 1'b0;
      results.valid <= 1'b0;
      idx           <= '0;
    end else begin
      if (finish && (!results.valid || results.ready)) begin
        results.valid            <= 1'b1;
        results.filtered_average <= AVG_W'(res);
        results.kept_count       <= COUNT_W'(kept);
        finish                   <= 1'b0;
      end else if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            sum   <= '0;
            cnt1  <= '0;
            idx   <= '0;
            state <= PASS1;
          end
        end
        PASS1: begin
          if (take1) begin
            sum  <= sum_next;
            cnt1 <= cnt1_next;
          end
          idx <= idx + IDX_W'(1);
          if (last) begin
            if (!take1 && cnt1 == '0) begin
              res    <= '0;
              kept   <= '0;
              finish <= 1'b1;
              state  <= IDLE;
            end else begin
              state <= LOAD1;
            end
          end
        end
        LOAD1: state <= DIV1;
        DIV1: begin
          if (div_done) begin
            mean  <= div_quotient[SAMPLE_BITS-1:0];
            state <= SCALE;
          end
        end
        SCALE: begin
          lo    <= (tolerance >= TOL_W'(PERCENT_SCALE)) ? '0 :
                   PROD_W'(mean) * PROD_W'(PERCENT_SCALE - FACTOR_W'(tolerance));
          hi    <= PROD_W'(mean) * PROD_W'(PERCENT_SCALE + FACTOR_W'(tolerance));
          sum   <= '0;
          cnt2  <= '0;
          idx   <= '0;
          state <= PASS2;
        end
        PASS2: begin
          if (take2) begin
            sum  <= sum_next;
            cnt2 <= cnt2_next;
          end
          idx <= idx + IDX_W'(1);
          if (last) begin
            if (!take2 && cnt2 == '0) begin
              res    <= mean;
              kept   <= cnt1;
              finish <= 1'b1;
              state  <= IDLE;
            end else begin
              state <= LOAD2;
            end
          end
        end
        LOAD2: state <= DIV2;
        DIV2: begin
          if (div_done) begin
            res    <= div_quotient[SAMPLE_BITS-1:0];
            kept   <= cnt2;
            finish <= 1'b1;
            state  <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/orwa_div.sv
module orwa_div #(
  parameter int DIVIDEND_W = 14,
  parameter int DIVISOR_W  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // one restoring step per cycle
  assign trial = {rem, quo[DIVIDEND_W-1]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && busy && (step == STEP_W'(1));
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dsr  <= divisor;
        step <= STEP_W'(DIVIDEND_W);
        busy <= 1'b1;
      end else if (busy) begin
        quo  <= {quo[DIVIDEND_W-2:0], ge};
        rem  <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        step <= step - STEP_W'(1);
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

FILE: rtl/core/orwa_checker.sv
module orwa_checker #(
  parameter int WINDOW_DEPTH = 10
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [orwa_pkg::AVG_W-1:0]  filtered_average,
  input logic [orwa_pkg::COUNT_W-1:0] kept_count
);
  import orwa_pkg::*;

  localparam logic SHALLOW = WINDOW_DEPTH < 16;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered_average) && $stable(kept_count))
    else $error("result changed while stalled");

  // one sample at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while busy");

  // empty window gives zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    SHALLOW && out_valid && kept_count == '0 |-> filtered_average == '0)
    else $error("nonzero average from empty window");

  a_kept_range: assert property (@(posedge clk) disable iff (rst)
    SHALLOW && out_valid |-> kept_count <= COUNT_W'(WINDOW_DEPTH))
    else $error("kept count beyond window depth");

endmodule

bind outlier_rejecting_window_average_core orwa_checker #(
  .WINDOW_DEPTH (WINDOW_DEPTH)
) u_orwa_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (samples.valid),
  .in_ready         (samples.ready),
  .out_valid        (results.valid),
  .out_ready        (results.ready),
  .filtered_average (results.filtered_average),
  .kept_count       (results.kept_count)
);

FILE: tb/sv/tb.sv
module tb;
  import orwa_pkg::*;

  localparam int WINDOW_DEPTH = 10;
  localparam int SAMPLE_BITS  = 10;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
  localparam int PERCENT      = 100;
  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 108;
  localparam int PRINT_CAP    = 40;
  localparam logic [ADDR_W-1:0] TOLERANCE_ADDR = {REG_TOLERANCE, 2'b00};

  typedef struct {
    logic [AVG_W-1:0]   filtered_average;
    logic [COUNT_W-1:0] kept_count;
  } window_result_t;

  typedef enum logic {ROW_SAMPLE, ROW_TOLERANCE} row_kind_t;

  typedef struct {
    row_kind_t      kind;
    logic [31:0]    value;
    bit             known;
    window_result_t want;
  } directed_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  orwa_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp ();
  orwa_result_if res ();

  outlier_rejecting_window_average_core #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .samples(smp),
    .results(res)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [SAMPLE_BITS-1:0] shadow_window [WINDOW_DEPTH];
  logic [TOL_W-1:0]       tol_setting;
  window_result_t         expected_averages [$];
  window_result_t         oldest;
  int                     mismatch_count = 0;
  int                     sender_idle_pct;
  int                     receiver_idle_pct;
  int                     quiet_cycles;

  directed_row_t dir_rows [24] = '{
    '{ROW_SAMPLE,    32'd0,         1'b1, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b1, '{10'd1023, 4'd1}},
    '{ROW_SAMPLE,    32'd1023,      1'b1, '{10'd1023, 4'd2}},
    '{ROW_SAMPLE,    32'd1,         1'b1, '{10'd682,  4'd3}},
    '{ROW_SAMPLE,    32'h2AA,       1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'h155,       1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd512,       1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd0,         1'b0, '{10'd0,    4'd0}},
    '{ROW_TOLERANCE, 32'd0,         1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1023,      1'b1, '{10'd1023, 4'd10}},
    '{ROW_TOLERANCE, 32'd100,       1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd0,         1'b1, '{10'd920,  4'd10}},
    '{ROW_TOLERANCE, 32'hFFFF_FFFF, 1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1,         1'b0, '{10'd0,    4'd0}},
    '{ROW_SAMPLE,    32'd1000,      1'b0, '{10'd0,    4'd0}}
  };

  function automatic window_result_t average_after_shift(input logic [SAMPLE_BITS-1:0] reading);
    window_result_t r;
    int unsigned    sum1, cnt1, sum2, cnt2, mean, lo, hi, scaled;
    int             i;
    sum1 = 0;
    cnt1 = 0;
    sum2 = 0;
    cnt2 = 0;
    for (i = WINDOW_DEPTH - 1; i > 0; i--) shadow_window[i] = shadow_window[i-1];
    shadow_window[0] = reading;
    for (i = 0; i < WINDOW_DEPTH; i++) begin
      if (shadow_window[i] != 0) begin
        sum1 += shadow_window[i];
        cnt1++;
      end
    end
    if (cnt1 == 0) begin
      r.filtered_average = '0;
      r.kept_count = '0;
      return r;
    end
    mean = sum1 / cnt1;
    lo = (tol_setting >= PERCENT) ? 0 : (PERCENT - tol_setting) * mean;
    hi = (PERCENT + tol_setting) * mean;
    for (i = 0; i < WINDOW_DEPTH; i++) begin
      scaled = PERCENT * shadow_window[i];
      if (scaled >= lo && scaled <= hi) begin
        sum2 += shadow_window[i];
        cnt2++;
      end
    end
    if (cnt2 == 0) begin
      r.filtered_average = mean[AVG_W-1:0];
      r.kept_count = cnt1[COUNT_W-1:0];
    end else begin
      sum2 = sum2 / cnt2;
      r.filtered_average = sum2[AVG_W-1:0];
      r.kept_count = cnt2[COUNT_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic put_sample(input logic [SAMPLE_BITS-1:0] reading, output window_result_t pred);
    while ($urandom_range(99) < sender_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.sample <= reading;
    @(posedge clk);
    while (!smp.ready) @(posedge clk);
    pred = average_after_shift(reading);
  endtask

  task automatic wait_idle();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (expected_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TOLERANCE_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tol_setting = value[TOL_W-1:0];
  endtask

  // result side: check each transfer, then stall at random
  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (expected_averages.size() == 0) begin
          report_mismatch("unexpected result, filtered_average", res.filtered_average, 0);
        end else begin
          oldest = expected_averages.pop_front();
          if (res.filtered_average !== oldest.filtered_average)
            report_mismatch("filtered_average", res.filtered_average, oldest.filtered_average);
          if (res.kept_count !== oldest.kept_count)
            report_mismatch("kept_count", res.kept_count, oldest.kept_count);
        end
      end
      res.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((smp.valid && smp.ready) || (res.valid && res.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    window_result_t pred;
    logic [DATA_W-1:0] wdata;
    int i, p, pick, spread, level, burst_center, burst_left;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    smp.valid = 1'b0;
    smp.sample = '0;
    res.ready = 1'b0;
    sender_idle_pct = 17;
    receiver_idle_pct = 53;
    tol_setting = TOL_RESET;
    for (i = 0; i < WINDOW_DEPTH; i++) shadow_window[i] = '0;
    burst_center = 0;
    burst_left = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < $size(dir_rows); i++) begin
      if (dir_rows[i].kind == ROW_TOLERANCE) begin
        wait_idle();
        write_tolerance(dir_rows[i].value);
      end else begin
        put_sample(dir_rows[i].value[SAMPLE_BITS-1:0], pred);
        expected_averages.push_back(dir_rows[i].known ? dir_rows[i].want : pred);
      end
    end

    for (p = 0; p < 6; p++) begin
      wait_idle();
      case (p / 2)
        0: begin
          sender_idle_pct = 17;
          receiver_idle_pct = 53;
        end
        1: begin
          sender_idle_pct = 53;
          receiver_idle_pct = 17;
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
        end
      endcase
      wdata = $urandom;
      case (p)
        0: wdata[TOL_W-1:0] = 7'd0;
        1: wdata[TOL_W-1:0] = TOL_W'($urandom_range(99, 1));
        2: wdata[TOL_W-1:0] = 7'd100;
        3: wdata[TOL_W-1:0] = 7'd127;
        4: wdata[TOL_W-1:0] = TOL_W'($urandom_range(126, 101));
        default: wdata[TOL_W-1:0] = TOL_W'($urandom_range(20, 1));
      endcase
      write_tolerance(wdata);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // bursts of readings clustered near the tolerance band, plus outliers
        if (burst_left == 0) begin
          burst_center = $urandom_range(SAMPLE_MAX);
          burst_left = $urandom_range(30, 4);
        end
        burst_left--;
        spread = 1 + burst_center * (tol_setting + 5) / PERCENT;
        pick = $urandom_range(99);
        if (pick < 62) level = burst_center + int'($urandom_range(2 * spread)) - spread;
        else if (pick < 77) level = $urandom_range(SAMPLE_MAX);
        else if (pick < 85) level = 0;
        else if (pick < 93) level = ($urandom_range(1) == 1) ? SAMPLE_MAX : 1;
        else level = $urandom_range(24, 1);
        if (level < 0) level = 0;
        if (level > SAMPLE_MAX) level = SAMPLE_MAX;
        put_sample(level[SAMPLE_BITS-1:0], pred);
        expected_averages.push_back(pred);
      end
    end

    wait_idle();
    if (mismatch_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: outlier_rejecting_window_average_core.f
rtl/core/orwa_pkg.sv
rtl/core/orwa_if.sv
rtl/core/orwa_div.sv
rtl/core/outlier_rejecting_window_average_core.sv
rtl/core/orwa_checker.sv
tb/sv/tb.sv
